/* hw/rtl/qpr_pkg.sv */
// Shared types, constants and term tables for the quaternion product/rotate datapath.
package qpr_pkg;

    localparam int NUM_COMP = 4;
    localparam int W_IDX    = 3;

    localparam logic OP_PRODUCT = 1'b0;
    localparam logic OP_ROTATE  = 1'b1;

    // Bit k set: term k of that component enters the sum negated.
    localparam logic [3:0] TERM_NEG [NUM_COMP] = '{4'b0100, 4'b0001, 4'b0010, 4'b0111};

    typedef struct packed {
        logic load;
        logic op;
    } stage_ctl_t;

    // Term k of component c multiplies q[k] by p[k ^ (3 - c)].
    function automatic logic [1:0] p_index(logic [1:0] c, logic [1:0] k);
        return k ^ (2'd3 - c);
    endfunction

endpackage

/* hw/rtl/qpr_mul.sv */
// Product stage: all sixteen partial products of one quaternion product, registered.
module qpr_mul #(
    parameter int PW = 17,
    parameter int QW = 16
) (
    input  logic                    clk,
    input  logic                    load,
    input  logic signed [PW-1:0]    p [qpr_pkg::NUM_COMP],
    input  logic signed [QW-1:0]    q [qpr_pkg::NUM_COMP],
    output logic signed [PW+QW-1:0] prod_reg [qpr_pkg::NUM_COMP][qpr_pkg::NUM_COMP]
);
    import qpr_pkg::*;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                for (int k = 0; k < NUM_COMP; k++)
                begin
                    prod_reg[c][k] <= p[p_index(2'(c), 2'(k))] * q[k];
                end
            end
        end
    end

endmodule

/* hw/rtl/qpr_sum.sv */
// Sum stage: signed four-term sums, arithmetic shift by the fraction bits, registered.
module qpr_sum #(
    parameter  int PRW = 33,
    parameter  int F   = 14,
    localparam int SW  = PRW + 2,
    localparam int OW  = (SW > F) ? (SW - F) : 1
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic signed [PRW-1:0] prod [qpr_pkg::NUM_COMP][qpr_pkg::NUM_COMP],
    output logic signed [OW-1:0]  sum_reg [qpr_pkg::NUM_COMP]
);
    import qpr_pkg::*;

    logic signed [SW-1:0] acc [NUM_COMP];
    logic signed [SW-1:0] shifted [NUM_COMP];

    always_comb
    begin
        logic signed [SW-1:0] term;
        term = '0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            acc[c] = '0;
            for (int k = 0; k < NUM_COMP; k++)
            begin
                term = SW'(prod[c][k]);
                if (TERM_NEG[c][k])
                    acc[c] = acc[c] - term;
                else
                    acc[c] = acc[c] + term;
            end
            shifted[c] = acc[c] >>> F;
        end
    end

    // Keep the shifted sum exactly; only the low OW bits can be significant.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                sum_reg[c] <= shifted[c][OW-1:0];
            end
        end
    end

endmodule

/* hw/rtl/qpr_sat.sv */
// Output stage: saturate to the component width, zero w on rotation, flag clipping.
module qpr_sat #(
    parameter int IW = 36,
    parameter int W  = 16
) (
    input  logic                   clk,
    input  qpr_pkg::stage_ctl_t    ctl,
    input  logic signed [IW-1:0]   val [qpr_pkg::NUM_COMP],
    output logic signed [W-1:0]    r_reg [qpr_pkg::NUM_COMP],
    output logic                   ovf_reg
);
    import qpr_pkg::*;

    localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] clip [NUM_COMP];
    logic [NUM_COMP-1:0] over;

    generate
        if (IW >= W)
        begin : g_clip
            always_comb
            begin
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    over[c] = !((&val[c][IW-1:W-1]) || (~|val[c][IW-1:W-1]));
                    if (!over[c])
                        clip[c] = val[c][W-1:0];
                    else if (val[c][IW-1])
                        clip[c] = MIN_VAL;
                    else
                        clip[c] = MAX_VAL;
                end
            end
        end
        else
        begin : g_ext
            always_comb
            begin
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    over[c] = 1'b0;
                    clip[c] = W'(val[c]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int c = 0; c < W_IDX; c++)
            begin
                r_reg[c] <= clip[c];
            end
            r_reg[W_IDX] <= (ctl.op == OP_ROTATE) ? '0 : clip[W_IDX];
            ovf_reg      <= (|over[W_IDX-1:0]) | ((ctl.op == OP_PRODUCT) & over[W_IDX]);
        end
    end

endmodule

/* hw/rtl/quaternion_product_and_rotate_top.sv */
// Top level: five-stage quaternion product / vector rotation pipeline with stream ports.
//
//  Channel   Direction  Word contents                                  Handshake
//  s_axis    in         tdata: a_x,a_y,a_z,a_w,b_x,b_y,b_z,b_w          tvalid/tready
//                       tuser: op (0 product, 1 rotate)
//  m_axis    out        tdata: r_x,r_y,r_z,r_w (zero padded to bytes)   tvalid/tready
//                       tuser: overflow
//
//  Throughput: one word per cycle while the output is not stalled.
//  Stages: product pass 1, sum pass 1, product pass 2, sum pass 2, saturate.
//  Products bypass the second pass (their result is carried alongside it).
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Stalls: each stage holds while it is full and the stage after it holds, so
//  bubbles are squeezed out and input is taken while a result waits.
module quaternion_product_and_rotate_top #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (low bits first)
    input  logic [8*COMPONENT_WIDTH-1:0] s_axis_tdata,
    // op
    input  logic [0:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // r_x, r_y, r_z, r_w, then zero fill (low bits first)
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // overflow
    output logic [0:0]                   m_axis_tuser
);
    import qpr_pkg::*;

    localparam int W          = COMPONENT_WIDTH;
    localparam int F          = FRACTION_BITS;
    localparam int PW1        = W + 1;                       // conj(A) needs one more bit
    localparam int PRW1       = PW1 + W;
    localparam int TW         = (PRW1 + 2 > F) ? (PRW1 + 2 - F) : 1;
    localparam int PRW2       = TW + W;
    localparam int RW         = (PRW2 + 2 > F) ? (PRW2 + 2 - F) : 1;
    localparam int FW         = (RW > TW) ? RW : TW;
    localparam int OUT_DATA_W = ((4*W + 7) / 8) * 8;
    localparam int NSTAGE     = 5;

    // ---------------- stage control ----------------
    logic [NSTAGE:1]   vld_reg;
    logic [NSTAGE:1]   vld_next;
    logic [NSTAGE+1:1] go;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        go[NSTAGE+1] = m_axis_tready;
        for (int k = NSTAGE; k >= 1; k--)
        begin
            go[k] = !vld_reg[k] || go[k+1];
        end
        vld_next = {vld_reg[NSTAGE-1:1], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NSTAGE; k++)
            begin
                if (go[k])
                    vld_reg[k] <= vld_next[k];
            end
        end
    end

    assign s_axis_tready = go[1];
    assign m_axis_tvalid = vld_reg[NSTAGE];

    // ---------------- input unpack and first-pass operands ----------------
    logic                op_in;
    logic signed [W-1:0]   a_in [NUM_COMP];
    logic signed [W-1:0]   b_in [NUM_COMP];
    logic signed [PW1-1:0] p1   [NUM_COMP];
    logic signed [W-1:0]   q1   [NUM_COMP];

    assign op_in = s_axis_tuser[0];

    // Rotation pass 1 is conj(A) * (v, 0); product is A * B directly.
    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            a_in[c] = s_axis_tdata[c*W +: W];
            b_in[c] = s_axis_tdata[(NUM_COMP+c)*W +: W];
            if (op_in == OP_ROTATE && c != W_IDX)
                p1[c] = -PW1'(a_in[c]);
            else
                p1[c] = PW1'(a_in[c]);
            if (op_in == OP_ROTATE && c == W_IDX)
                q1[c] = '0;
            else
                q1[c] = b_in[c];
        end
    end

    // ---------------- stage 1: first products ----------------
    logic signed [PRW1-1:0] prod1 [NUM_COMP][NUM_COMP];
    logic                   op1_reg;
    logic signed [W-1:0]    a1_reg [NUM_COMP];

    qpr_mul #(.PW(PW1), .QW(W)) u_mul1 (
        .clk      (clk),
        .load     (go[1]),
        .p        (p1),
        .q        (q1),
        .prod_reg (prod1)
    );

    // ---------------- stage 2: first sums (T for rotation, result for product) ----
    logic signed [TW-1:0] t2 [NUM_COMP];
    logic                 op2_reg;
    logic signed [W-1:0]  a2_reg [NUM_COMP];

    qpr_sum #(.PRW(PRW1), .F(F)) u_sum1 (
        .clk     (clk),
        .load    (go[2]),
        .prod    (prod1),
        .sum_reg (t2)
    );

    // ---------------- stage 3: second products T * A ----------------
    logic signed [PRW2-1:0] prod2 [NUM_COMP][NUM_COMP];
    logic                   op3_reg;
    logic signed [TW-1:0]   t3_reg [NUM_COMP];

    qpr_mul #(.PW(TW), .QW(W)) u_mul2 (
        .clk      (clk),
        .load     (go[3]),
        .p        (t2),
        .q        (a2_reg),
        .prod_reg (prod2)
    );

    // ---------------- stage 4: second sums ----------------
    logic signed [RW-1:0] r4 [NUM_COMP];
    logic                 op4_reg;
    logic signed [TW-1:0] t4_reg [NUM_COMP];

    qpr_sum #(.PRW(PRW2), .F(F)) u_sum2 (
        .clk     (clk),
        .load    (go[4]),
        .prod    (prod2),
        .sum_reg (r4)
    );

    // Sidebands ride along with the datapath stages.
    always_ff @(posedge clk)
    begin
        if (go[1])
        begin
            op1_reg <= op_in;
            a1_reg  <= a_in;
        end
        if (go[2])
        begin
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
        end
        if (go[3])
        begin
            op3_reg <= op2_reg;
            t3_reg  <= t2;
        end
        if (go[4])
        begin
            op4_reg <= op3_reg;
            t4_reg  <= t3_reg;
        end
    end

    // ---------------- stage 5: select, saturate, output register ----------------
    logic signed [FW-1:0] fin [NUM_COMP];
    logic signed [W-1:0]  r_out [NUM_COMP];
    logic                 ovf_out;
    stage_ctl_t           ctl5;

    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            if (op4_reg == OP_ROTATE)
                fin[c] = FW'(r4[c]);
            else
                fin[c] = FW'(t4_reg[c]);
        end
        ctl5.load = go[5];
        ctl5.op   = op4_reg;
    end

    qpr_sat #(.IW(FW), .W(W)) u_sat (
        .clk     (clk),
        .ctl     (ctl5),
        .val     (fin),
        .r_reg   (r_out),
        .ovf_reg (ovf_out)
    );

    assign m_axis_tdata = OUT_DATA_W'({r_out[3], r_out[2], r_out[1], r_out[0]});
    assign m_axis_tuser = ovf_out;

endmodule

/* hw/rtl/qpr_chk.sv */
// Port-level checker for the quaternion product/rotate top, attached by bind.
module qpr_chk #(
    parameter int COMPONENT_WIDTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0]                   m_axis_tuser
);

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Refuse input only when the output is stalled (the design also needs every stage full).
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without output stall");

    // With the sink ready, an accepted word reaches the output once it has passed every stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted word did not reach output in time");

endmodule

bind quaternion_product_and_rotate_top qpr_chk #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qpr_chk (.*);
